// ===== rtl/core/integer_atan2_degrees_unit_macros.svh =====
// ----------------------------------------------------------------------------
// integer_atan2_degrees_unit_macros
// assertion macros shared by the heading unit
// ----------------------------------------------------------------------------
`ifndef INTEGER_ATAN2_DEGREES_UNIT_MACROS_SVH
`define INTEGER_ATAN2_DEGREES_UNIT_MACROS_SVH

// same-cycle implication
`define IADU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IADU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/iadu_pkg.sv =====
// ----------------------------------------------------------------------------
// iadu_pkg
// types, constants and the ratio-to-angle table of the heading unit
// ----------------------------------------------------------------------------
package iadu_pkg;

	localparam int unsigned MagW       = 9;
	localparam int unsigned NumW       = 12;
	localparam int unsigned AngW       = 7;
	localparam int unsigned BitsPerDiv = 3;
	localparam int unsigned DivStages  = NumW / BitsPerDiv;

	typedef struct packed {
		logic              special;
		logic signed [8:0] spec_heading;
		logic              negx;
		logic              negy;
		logic              xbig;
	} flags_t;

	typedef struct packed {
		logic [MagW-1:0] rem;
		logic [NumW-1:0] quo;
		logic [NumW-1:0] num;
		logic [MagW-1:0] dvs;
		flags_t          flags;
	} div_t;

	typedef struct packed {
		logic [AngW-1:0] ang;
		flags_t          flags;
	} ang_t;

	// angle 45..89 whose tangent is s/10
	function automatic logic [AngW-1:0] ratio_angle(input logic [NumW-1:0] s);
		logic [AngW-1:0] a;
		if (s >= 12'd573) a = 7'd89;
		else if (s >= 12'd287) a = 7'd88;
		else if (s >= 12'd191) a = 7'd87;
		else if (s >= 12'd144) a = 7'd86;
		else if (s >= 12'd115) a = 7'd85;
		else if (s >= 12'd96) a = 7'd84;
		else if (s >= 12'd82) a = 7'd83;
		else if (s >= 12'd72) a = 7'd82;
		else if (s >= 12'd64) a = 7'd81;
		else if (s >= 12'd57) a = 7'd80;
		else if (s >= 12'd52) a = 7'd79;
		else begin
			case (s[5:0])
				6'd10: a = 7'd45;
				6'd11: a = 7'd47;
				6'd12: a = 7'd50;
				6'd13: a = 7'd52;
				6'd14: a = 7'd54;
				6'd15: a = 7'd56;
				6'd16: a = 7'd57;
				6'd17: a = 7'd59;
				6'd18: a = 7'd60;
				6'd19: a = 7'd62;
				6'd20: a = 7'd63;
				6'd21: a = 7'd64;
				6'd22: a = 7'd65;
				6'd23: a = 7'd66;
				6'd24: a = 7'd67;
				6'd25: a = 7'd68;
				6'd26: a = 7'd68;
				6'd27: a = 7'd69;
				6'd28: a = 7'd70;
				6'd29: a = 7'd70;
				6'd30: a = 7'd71;
				6'd31: a = 7'd72;
				6'd32: a = 7'd72;
				6'd33: a = 7'd73;
				6'd34: a = 7'd73;
				6'd35: a = 7'd74;
				6'd36: a = 7'd74;
				6'd37: a = 7'd74;
				6'd38: a = 7'd75;
				6'd39: a = 7'd75;
				6'd40: a = 7'd75;
				6'd41: a = 7'd76;
				6'd42: a = 7'd76;
				6'd43: a = 7'd76;
				6'd44: a = 7'd77;
				6'd45: a = 7'd77;
				6'd46: a = 7'd77;
				6'd47: a = 7'd77;
				6'd48: a = 7'd78;
				6'd49: a = 7'd78;
				6'd50: a = 7'd78;
				6'd51: a = 7'd78;
				default: a = 7'd45;
			endcase
		end
		return a;
	endfunction

endpackage

// ===== rtl/core/iadu_prep.sv =====
// ----------------------------------------------------------------------------
// iadu_prep
// magnitudes, octant flags, special cases and the scaled dividend
// ----------------------------------------------------------------------------
module iadu_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [8:0]   delta_x,
	input  logic signed [8:0]   delta_y,
	output logic                out_valid,
	output iadu_pkg::div_t      out_div
);

	logic                          negx;
	logic                          negy;
	logic [iadu_pkg::MagW-1:0]     ax;
	logic [iadu_pkg::MagW-1:0]     ay;
	logic [iadu_pkg::MagW-1:0]     big;
	logic [iadu_pkg::MagW-1:0]     small_mag;
	iadu_pkg::div_t                nxt;
	logic                          valid_s1;
	iadu_pkg::div_t                div_s1;

	always_comb begin
		negx      = delta_x[8];
		negy      = delta_y[8];
		ax        = negx ? 9'(-delta_x) : 9'(delta_x);
		ay        = negy ? 9'(-delta_y) : 9'(delta_y);
		big       = (ax <= ay) ? ay : ax;
		small_mag = (ax <= ay) ? ax : ay;
		nxt.rem   = '0;
		nxt.quo   = '0;
		nxt.num   = {big, 3'b000} + {2'b00, big, 1'b0};
		nxt.dvs   = small_mag;
		nxt.flags.negx = negx;
		nxt.flags.negy = negy;
		nxt.flags.xbig = ax > ay;
		if (ay == '0) begin
			nxt.flags.special      = 1'b1;
			nxt.flags.spec_heading = negx ? 9'sd180 : 9'sd0;
		end else if (ax == '0) begin
			nxt.flags.special      = 1'b1;
			nxt.flags.spec_heading = negy ? -9'sd90 : 9'sd90;
		end else begin
			nxt.flags.special      = 1'b0;
			nxt.flags.spec_heading = 9'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_div   = div_s1;

endmodule

// ===== rtl/core/iadu_div_stage.sv =====
// ----------------------------------------------------------------------------
// iadu_div_stage
// one stage of the restoring divider, three quotient bits per stage
// ----------------------------------------------------------------------------
module iadu_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  iadu_pkg::div_t in_div,
	output logic           out_valid,
	output iadu_pkg::div_t out_div
);

	iadu_pkg::div_t          nxt;
	logic [iadu_pkg::MagW:0] trial;
	logic                    valid_sn;
	iadu_pkg::div_t          div_sn;

	always_comb begin
		nxt   = in_div;
		trial = '0;
		for (int i = 0; i < int'(iadu_pkg::BitsPerDiv); i++) begin
			trial = {nxt.rem, nxt.num[iadu_pkg::NumW-1]};
			nxt.num = {nxt.num[iadu_pkg::NumW-2:0], 1'b0};
			if (trial >= {1'b0, nxt.dvs}) begin
				nxt.rem = iadu_pkg::MagW'(trial - {1'b0, nxt.dvs});
				nxt.quo = {nxt.quo[iadu_pkg::NumW-2:0], 1'b1};
			end else begin
				nxt.rem = trial[iadu_pkg::MagW-1:0];
				nxt.quo = {nxt.quo[iadu_pkg::NumW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_sn <= nxt;
		end
	end

	assign out_valid = valid_sn;
	assign out_div   = div_sn;

endmodule

// ===== rtl/core/iadu_angle.sv =====
// ----------------------------------------------------------------------------
// iadu_angle
// rounds the ratio and maps it to an angle of 45 to 89 degrees
// ----------------------------------------------------------------------------
module iadu_angle (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  iadu_pkg::div_t in_div,
	output logic           out_valid,
	output iadu_pkg::ang_t out_ang
);

	logic [iadu_pkg::NumW-1:0] s;
	iadu_pkg::ang_t            nxt;
	logic                      valid_s6;
	iadu_pkg::ang_t            ang_s6;

	always_comb begin
		s = in_div.quo + {11'd0, (in_div.rem >= {1'b0, in_div.dvs[iadu_pkg::MagW-1:1]})};
		nxt.ang   = iadu_pkg::ratio_angle(s);
		nxt.flags = in_div.flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s6 <= nxt;
		end
	end

	assign out_valid = valid_s6;
	assign out_ang   = ang_s6;

endmodule

// ===== rtl/core/iadu_quad.sv =====
// ----------------------------------------------------------------------------
// iadu_quad
// octant, quadrant and sign correction into the output register
// ----------------------------------------------------------------------------
module iadu_quad (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  iadu_pkg::ang_t     in_ang,
	output logic               out_valid,
	output logic signed [8:0]  heading
);

	logic [6:0]        oct;
	logic [7:0]        half;
	logic signed [8:0] nxt;
	logic              valid_s7;
	logic signed [8:0] heading_s7;

	always_comb begin
		oct  = in_ang.flags.xbig ? 7'(7'd90 - in_ang.ang) : in_ang.ang;
		half = in_ang.flags.negx ? 8'(8'd180 - {1'b0, oct}) : {1'b0, oct};
		if (in_ang.flags.special) begin
			nxt = in_ang.flags.spec_heading;
		end else if (in_ang.flags.negy) begin
			nxt = -$signed({1'b0, half});
		end else begin
			nxt = $signed({1'b0, half});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			heading_s7 <= nxt;
		end
	end

	assign out_valid = valid_s7;
	assign heading   = heading_s7;

endmodule

// ===== rtl/core/integer_atan2_degrees_unit.sv =====
// ----------------------------------------------------------------------------
// integer_atan2_degrees_unit
// heading of a signed vector in whole degrees, -179 to 180
// ----------------------------------------------------------------------------
// One vector is taken every cycle unless in_stall is high, and its heading
// passes through one stage for magnitudes and the scaled dividend, four stages
// of a restoring divider at three quotient bits each, one stage for rounding
// and the angle lookup, and the output register for quadrant and sign. Each
// stage moves on whenever the stage after it is empty or moving, so bubbles
// are squeezed out while the output is stalled and the input stalls only when
// every stage holds a beat.
// ----------------------------------------------------------------------------
`include "integer_atan2_degrees_unit_macros.svh"

module integer_atan2_degrees_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [8:0] delta_x,
	input  logic signed [8:0] delta_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [8:0] heading_deg
);

	localparam int unsigned LastDiv = iadu_pkg::DivStages + 1;

	logic           en     [1:7];
	logic           vld    [1:7];
	iadu_pkg::div_t div_s  [1:LastDiv];
	iadu_pkg::ang_t ang_s6;

	always_comb begin
		en[7] = !vld[7] || !out_stall;
		for (int k = 6; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld[7];

	iadu_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[1]),
		.in_valid  (in_valid),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.out_valid (vld[1]),
		.out_div   (div_s[1])
	);

	for (genvar g = 2; g <= LastDiv; g++) begin : g_div
		iadu_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en[g]),
			.in_valid  (vld[g-1]),
			.in_div    (div_s[g-1]),
			.out_valid (vld[g]),
			.out_div   (div_s[g])
		);
	end

	iadu_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[6]),
		.in_valid  (vld[LastDiv]),
		.in_div    (div_s[LastDiv]),
		.out_valid (vld[6]),
		.out_ang   (ang_s6)
	);

	iadu_quad u_quad (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[7]),
		.in_valid  (vld[6]),
		.in_ang    (ang_s6),
		.out_valid (vld[7]),
		.heading   (heading_deg)
	);

	`IADU_ASSERT_IMP(a_stall_full, in_stall, vld[1] && vld[2] && vld[3] && vld[4] && vld[5] && vld[6] && vld[7], "input stalled with a free stage")
	`IADU_ASSERT_NXT(a_angle_hold, vld[6] && !en[6], vld[6] && $stable(ang_s6), "held angle beat changed")
	`IADU_ASSERT_IMP(a_rem_range, vld[LastDiv] && !div_s[LastDiv].flags.special, div_s[LastDiv].rem < div_s[LastDiv].dvs, "divider remainder out of range")
	`IADU_ASSERT_IMP(a_ang_range, vld[6] && !ang_s6.flags.special, ang_s6.ang >= 7'd45 && ang_s6.ang <= 7'd89, "octant angle out of range")

endmodule
